FILE: sv/cbc_pkg.sv
`default_nettype none
package cbc_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_DATA = 2'd2,
        TGT_NONE = 2'd3
    } target_t;

    localparam logic [1:0] CFG_ROM_MASK      = 2'd0;
    localparam logic [1:0] CFG_RAM_PRESENT   = 2'd1;
    localparam logic [1:0] CFG_RAM_MASK      = 2'd2;
    localparam logic [1:0] CFG_CLOCK_PRESENT = 2'd3;

    localparam logic [2:0] RTC_SEC  = 3'd0;
    localparam logic [2:0] RTC_MIN  = 3'd1;
    localparam logic [2:0] RTC_HOUR = 3'd2;
    localparam logic [2:0] RTC_DAYL = 3'd3;
    localparam logic [2:0] RTC_DAYH = 3'd4;
    localparam int RTC_REGS = 5;

    localparam logic [7:0] SEL_CLOCK_FIRST = 8'h08;
    localparam logic [7:0] SEL_CLOCK_LAST  = 8'h0C;
    localparam logic [7:0] SEL_RAM_LAST    = 8'h07;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS       = 8'hFF;

    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;

    localparam int DAYH_DAY8  = 0;
    localparam int DAYH_HALT  = 6;
    localparam int DAYH_CARRY = 7;

    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [2:0] idx;
        logic       latch;
        logic [7:0] wdata;
    } rtc_ctrl_t;

    typedef struct packed {
        logic       en_we;
        logic       en_val;
        logic       bank_we;
        logic [6:0] bank_val;
        logic       sel_we;
        logic       latch_we;
    } map_upd_t;

    function automatic logic [2:0] div_by_60(input logic [8:0] v);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            if (v >= 9'(k * SEC_PER_MIN))
            begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] div_by_24(input logic [8:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= 10; k++)
        begin
            if (v >= 9'(k * HOUR_PER_DAY))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

endpackage
`default_nettype wire

FILE: sv/cbc_rtc.sv
`default_nettype none
module cbc_rtc
    import cbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  rtc_ctrl_t ctrl,
    input  logic [2:0] rd_idx,
    output logic [7:0] rd_byte
);

    logic [7:0] sec_reg, min_reg, hour_reg, dayl_reg, dayh_reg;
    logic [7:0] sec_next, min_next, hour_next, dayl_next, dayh_next;
    logic [7:0] latched_reg [RTC_REGS];

    logic [8:0] s_sum, m_sum, h_sum;
    logic [2:0] s_q, m_q;
    logic [3:0] h_q;
    logic [9:0] d_sum;

    always_comb
    begin
        s_sum = {1'b0, sec_reg} + 9'd1;
        s_q   = div_by_60(s_sum);
        m_sum = {1'b0, min_reg} + 9'(s_q);
        m_q   = div_by_60(m_sum);
        h_sum = {1'b0, hour_reg} + 9'(m_q);
        h_q   = div_by_24(h_sum);
        d_sum = {1'b0, dayh_reg[DAYH_DAY8], dayl_reg} + 10'(h_q);

        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        dayl_next = dayl_reg;
        dayh_next = dayh_reg;

        if (ctrl.tick && !dayh_reg[DAYH_HALT])
        begin
            sec_next  = 8'(s_sum - 9'(s_q) * 9'(SEC_PER_MIN));
            min_next  = 8'(m_sum - 9'(m_q) * 9'(MIN_PER_HOUR));
            hour_next = 8'(h_sum - 9'(h_q) * 9'(HOUR_PER_DAY));
            dayl_next = d_sum[7:0];
            dayh_next = {dayh_reg[DAYH_CARRY] | d_sum[9], dayh_reg[6:1], d_sum[8]};
        end
        else if (ctrl.wr)
        begin
            case (ctrl.idx)
                RTC_SEC:  sec_next  = ctrl.wdata;
                RTC_MIN:  min_next  = ctrl.wdata;
                RTC_HOUR: hour_next = ctrl.wdata;
                RTC_DAYL: dayl_next = ctrl.wdata;
                default:  dayh_next = ctrl.wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= '0;
            min_reg  <= '0;
            hour_reg <= '0;
            dayl_reg <= '0;
            dayh_reg <= '0;
            for (int i = 0; i < RTC_REGS; i++)
            begin
                latched_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            dayl_reg <= dayl_next;
            dayh_reg <= dayh_next;
            if (ctrl.latch)
            begin
                latched_reg[RTC_SEC]  <= sec_reg;
                latched_reg[RTC_MIN]  <= min_reg;
                latched_reg[RTC_HOUR] <= hour_reg;
                latched_reg[RTC_DAYL] <= dayl_reg;
                latched_reg[RTC_DAYH] <= dayh_reg;
            end
        end
    end

    always_comb
    begin
        case (rd_idx)
            RTC_SEC:  rd_byte = latched_reg[RTC_SEC];
            RTC_MIN:  rd_byte = latched_reg[RTC_MIN];
            RTC_HOUR: rd_byte = latched_reg[RTC_HOUR];
            RTC_DAYL: rd_byte = latched_reg[RTC_DAYL];
            RTC_DAYH: rd_byte = latched_reg[RTC_DAYH];
            default:  rd_byte = latched_reg[RTC_SEC];
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/cbc_decode.sv
`default_nettype none
module cbc_decode
    import cbc_pkg::*;
(
    input  logic [1:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [6:0]  rom_bank_mask,
    input  logic        ram_present,
    input  logic [2:0]  ram_bank_mask,
    input  logic        clock_present,
    input  logic        ram_enabled,
    input  logic [6:0]  rom_bank,
    input  logic [7:0]  sel,
    input  logic [7:0]  last_latch,
    input  logic [7:0]  clock_byte,
    output rtc_ctrl_t   rtc_ctrl,
    output map_upd_t    upd,
    output target_t     target,
    output logic [20:0] mapped_address,
    output logic        write_enable,
    output logic [7:0]  read_data
);

    logic ram_ok, clk_ok, ram_win;
    logic [20:0] ram_addr;
    op_t op;

    always_comb
    begin
        op       = op_t'(operation);
        ram_ok   = ram_enabled && ram_present && (sel <= SEL_RAM_LAST);
        clk_ok   = ram_enabled && clock_present
                   && (sel >= SEL_CLOCK_FIRST) && (sel <= SEL_CLOCK_LAST);
        ram_win  = (address[15:13] == 3'b101);
        ram_addr = 21'({sel[2:0] & ram_bank_mask, address[12:0]});

        target         = TGT_NONE;
        mapped_address = '0;
        write_enable   = 1'b0;
        read_data      = '0;

        rtc_ctrl       = '0;
        rtc_ctrl.idx   = sel[2:0];
        rtc_ctrl.wdata = data;
        upd            = '0;
        upd.en_val     = (data[3:0] == RAM_ENABLE_KEY);
        upd.bank_val   = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];

        case (op)
            OP_READ:
            begin
                read_data = OPEN_BUS;
                if (!address[15])
                begin
                    target    = TGT_ROM;
                    read_data = '0;
                    if (address[14])
                    begin
                        mapped_address = {rom_bank & rom_bank_mask, address[13:0]};
                    end
                    else
                    begin
                        mapped_address = 21'(address[13:0]);
                    end
                end
                else if (ram_win)
                begin
                    target = TGT_DATA;
                    if (ram_ok)
                    begin
                        target         = TGT_RAM;
                        read_data      = '0;
                        mapped_address = ram_addr;
                    end
                    else if (clk_ok)
                    begin
                        read_data = clock_byte;
                    end
                end
            end
            OP_WRITE:
            begin
                case (address[15:13])
                    3'b000: upd.en_we   = 1'b1;
                    3'b001: upd.bank_we = 1'b1;
                    3'b010: upd.sel_we  = 1'b1;
                    3'b011:
                    begin
                        upd.latch_we   = 1'b1;
                        rtc_ctrl.latch = (last_latch == 8'd0) && (data == 8'd1);
                    end
                    3'b101:
                    begin
                        if (ram_ok)
                        begin
                            target         = TGT_RAM;
                            write_enable   = 1'b1;
                            mapped_address = ram_addr;
                        end
                        else if (clk_ok)
                        begin
                            target      = TGT_DATA;
                            rtc_ctrl.wr = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: rtc_ctrl.tick = clock_present;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/cartridge_bank_controller_rtc_unit.sv
// Banked ROM/RAM cartridge mapper with a real-time clock. Each input beat is
// a bus read or write, a one-second tick or a no-op, and gives exactly one
// result beat with the target, the physical ROM or RAM address, the RAM write
// strobe and the clock or open-bus read byte. A beat passes the input and the
// result register in turn; a new beat is taken every cycle unless out_stall
// holds the result. Mapper and clock state update with the result register,
// so the next beat sees it at once. The user must write configuration through
// cfg_we/cfg_index/cfg_data with no beat in flight; the block does not check.
`default_nettype none
module cartridge_bank_controller_rtc_unit
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  target,
    output logic [20:0] mapped_address,
    output logic        write_enable,
    output logic [7:0]  read_data
);

    logic [6:0] rom_mask_reg;
    logic       ram_present_reg;
    logic [2:0] ram_mask_reg;
    logic       clock_present_reg;

    logic       ram_enabled_reg;
    logic [6:0] rom_bank_reg;
    logic [7:0] sel_reg;
    logic [7:0] last_latch_reg;

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    logic        out_valid_reg;
    logic [1:0]  target_reg;
    logic [20:0] mapped_reg;
    logic        we_reg;
    logic [7:0]  rdata_reg;

    logic        advance;
    rtc_ctrl_t   rtc_ctrl;
    map_upd_t    upd;
    target_t     tgt_next;
    logic [20:0] mapped_next;
    logic        we_next;
    logic [7:0]  rdata_next;
    logic [7:0]  clock_byte;

    assign advance  = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_mask_reg      <= 7'h7F;
            ram_present_reg   <= 1'b1;
            ram_mask_reg      <= 3'd3;
            clock_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROM_MASK:      rom_mask_reg      <= cfg_data;
                CFG_RAM_PRESENT:   ram_present_reg   <= cfg_data[0];
                CFG_RAM_MASK:      ram_mask_reg      <= cfg_data[2:0];
                CFG_CLOCK_PRESENT: clock_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg   <= operation;
            addr_reg <= address;
            data_reg <= data;
        end
    end

    cbc_decode u_decode (
        .operation      (op_reg),
        .address        (addr_reg),
        .data           (data_reg),
        .rom_bank_mask  (rom_mask_reg),
        .ram_present    (ram_present_reg),
        .ram_bank_mask  (ram_mask_reg),
        .clock_present  (clock_present_reg),
        .ram_enabled    (ram_enabled_reg),
        .rom_bank       (rom_bank_reg),
        .sel            (sel_reg),
        .last_latch     (last_latch_reg),
        .clock_byte     (clock_byte),
        .rtc_ctrl       (rtc_ctrl),
        .upd            (upd),
        .target         (tgt_next),
        .mapped_address (mapped_next),
        .write_enable   (we_next),
        .read_data      (rdata_next)
    );

    cbc_rtc u_rtc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .ctrl    (rtc_ctrl),
        .rd_idx  (sel_reg[2:0]),
        .rd_byte (clock_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg <= 1'b0;
            rom_bank_reg    <= 7'd1;
            sel_reg         <= '0;
            last_latch_reg  <= '0;
        end
        else if (advance)
        begin
            if (upd.en_we)
            begin
                ram_enabled_reg <= upd.en_val;
            end
            if (upd.bank_we)
            begin
                rom_bank_reg <= upd.bank_val;
            end
            if (upd.sel_we)
            begin
                sel_reg <= data_reg;
            end
            if (upd.latch_we)
            begin
                last_latch_reg <= data_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            target_reg <= tgt_next;
            mapped_reg <= mapped_next;
            we_reg     <= we_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target         = target_reg;
    assign mapped_address = mapped_reg;
    assign write_enable   = we_reg;
    assign read_data      = rdata_reg;

endmodule
`default_nettype wire

FILE: sv/cbc_checker.sv
`default_nettype none
module cbc_checker
    import cbc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  target,
    input logic [20:0] mapped_address,
    input logic        write_enable,
    input logic [7:0]  read_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target)
            && $stable(mapped_address) && $stable(write_enable) && $stable(read_data))
        else $error("result beat changed while stalled");

    a_we_ram_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> target == TGT_RAM)
        else $error("write strobe outside external RAM");

    a_rom_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == TGT_ROM |-> read_data == 8'd0 && !write_enable)
        else $error("ROM beat carries data or write");

    a_none_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == TGT_NONE || target == TGT_DATA)
            |-> mapped_address == 21'd0 && !write_enable)
        else $error("unmapped beat carries an address");

    a_ram_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == TGT_RAM
            |-> mapped_address[20:16] == 5'd0 && read_data == 8'd0)
        else $error("RAM address out of range");

endmodule

bind cartridge_bank_controller_rtc_unit cbc_checker u_cbc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .target         (target),
    .mapped_address (mapped_address),
    .write_enable   (write_enable),
    .read_data      (read_data)
);
`default_nettype wire
